@@ rtl/assc_pkg.sv @@
// ----------------------------------------------------------------------------
// assc_pkg
// Shared types, codes and constants of the adaptive step size controller.
// ----------------------------------------------------------------------------
package assc_pkg;

    // Datapath operations issued by the controller
    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_LOG_INIT,
        DP_LOG_SQ,
        DP_LOG_MUL,
        DP_LOG_ACC,
        DP_EXP_INIT,
        DP_EXP_STEP,
        DP_EXP_FIN,
        DP_CLAMP,
        DP_MUL_LO,
        DP_MUL_HI,
        DP_FINISH
    } t_dp_op;

    // Operand of the log2 unit
    typedef enum logic [1:0] {
        SRC_HEADROOM,
        SRC_ERROR,
        SRC_HISTORY
    } t_log_src;

    typedef struct packed {
        t_dp_op     op;
        t_log_src   src;
        logic [3:0] k;
    } t_dp_cmd;

    typedef struct packed {
        logic good;      // error within tolerance
        logic skip_log;  // scale known without logs
    } t_dp_status;

    // Register indexes
    localparam logic [2:0] CFG_HEADROOM   = 3'd0;
    localparam logic [2:0] CFG_ALPHA      = 3'd1;
    localparam logic [2:0] CFG_BETA       = 3'd2;
    localparam logic [2:0] CFG_MIN_SCALE  = 3'd3;
    localparam logic [2:0] CFG_MAX_SCALE  = 3'd4;
    localparam logic [2:0] CFG_STEP_MIN   = 3'd5;
    localparam logic [2:0] CFG_STEP_MAX   = 3'd6;

    // step_status codes
    localparam logic [1:0] STATUS_OK  = 2'd0;
    localparam logic [1:0] STATUS_MIN = 2'd1;
    localparam logic [1:0] STATUS_MAX = 2'd2;

    // scale_clamp codes
    localparam logic [1:0] CLAMP_NONE = 2'd0;
    localparam logic [1:0] CLAMP_MIN  = 2'd1;
    localparam logic [1:0] CLAMP_MAX  = 2'd2;

    localparam logic [15:0] RESET_HEADROOM  = 16'd29491;
    localparam logic [15:0] RESET_ALPHA     = 16'd2294;
    localparam logic [15:0] RESET_BETA      = 16'd1311;
    localparam logic [15:0] RESET_MIN_SCALE = 16'd819;
    localparam logic [15:0] RESET_MAX_SCALE = 16'd40960;

    // Unity scale in Q.12
    localparam logic [31:0] SCALE_ONE = 32'd4096;

    // 2^(2^-k) in Q2.30, k = 1..14
    localparam logic [31:0] ROOT_TAB [14] = '{
        32'd1518500250, 32'd1276901417, 32'd1170923762, 32'd1121280436,
        32'd1097253708, 32'd1085434106, 32'd1079572136, 32'd1076653033,
        32'd1075196443, 32'd1074468887, 32'd1074105294, 32'd1073923544,
        32'd1073832680, 32'd1073787250
    };

endpackage

@@ rtl/assc_ctrl.sv @@
// ----------------------------------------------------------------------------
// assc_ctrl
// Sequencer: walks the log, exponent and scaling steps of one item.
// ----------------------------------------------------------------------------
module assc_ctrl #(
    parameter int LOG_TABLE_BITS = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    input  assc_pkg::t_dp_status  i_status,
    output assc_pkg::t_dp_cmd     o_cmd
);
    import assc_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOG_INIT,
        ST_LOG_SQ,
        ST_LOG_MUL,
        ST_LOG_ACC,
        ST_EXP_INIT,
        ST_EXP_STEP,
        ST_EXP_FIN,
        ST_CLAMP,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_DONE
    } t_state;

    localparam logic [3:0] SQ_LAST  = 4'd15;
    localparam logic [3:0] EXP_LAST = 4'(LOG_TABLE_BITS - 1);

    t_state     r_state;
    t_log_src   r_src;
    logic [3:0] r_cnt;
    logic       r_out_valid;
    t_log_src   last_src;

    assign last_src    = i_status.good ? SRC_HISTORY : SRC_ERROR;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd.op  = DP_NOP;
        o_cmd.src = r_src;
        o_cmd.k   = r_cnt;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = DP_LOAD;
                end
            end
            ST_LOG_INIT: begin
                if (!i_status.skip_log) begin
                    o_cmd.op = DP_LOG_INIT;
                end
            end
            ST_LOG_SQ:   o_cmd.op = DP_LOG_SQ;
            ST_LOG_MUL:  o_cmd.op = DP_LOG_MUL;
            ST_LOG_ACC:  o_cmd.op = DP_LOG_ACC;
            ST_EXP_INIT: o_cmd.op = DP_EXP_INIT;
            ST_EXP_STEP: o_cmd.op = DP_EXP_STEP;
            ST_EXP_FIN:  o_cmd.op = DP_EXP_FIN;
            ST_CLAMP:    o_cmd.op = DP_CLAMP;
            ST_MUL_LO:   o_cmd.op = DP_MUL_LO;
            ST_MUL_HI:   o_cmd.op = DP_MUL_HI;
            ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.op = DP_FINISH;
                end
            end
            default: o_cmd.op = DP_NOP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_src       <= SRC_HEADROOM;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // drop the held result once it transfers; a new one may replace it
            if (o_cmd.op == DP_FINISH) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_src   <= SRC_HEADROOM;
                        r_state <= ST_LOG_INIT;
                    end
                end
                ST_LOG_INIT: begin
                    r_cnt   <= '0;
                    r_state <= i_status.skip_log ? ST_CLAMP : ST_LOG_SQ;
                end
                ST_LOG_SQ: begin
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == SQ_LAST) begin
                        r_state <= ST_LOG_MUL;
                    end
                end
                ST_LOG_MUL: r_state <= ST_LOG_ACC;
                ST_LOG_ACC: begin
                    if (r_src == last_src) begin
                        r_state <= ST_EXP_INIT;
                    end else begin
                        r_src   <= t_log_src'(r_src + 2'd1);
                        r_state <= ST_LOG_INIT;
                    end
                end
                ST_EXP_INIT: begin
                    r_cnt   <= '0;
                    r_state <= ST_EXP_STEP;
                end
                ST_EXP_STEP: begin
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == EXP_LAST) begin
                        r_state <= ST_EXP_FIN;
                    end
                end
                ST_EXP_FIN: r_state <= ST_CLAMP;
                ST_CLAMP:   r_state <= ST_MUL_LO;
                ST_MUL_LO:  r_state <= ST_MUL_HI;
                ST_MUL_HI:  r_state <= ST_DONE;
                ST_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    a_finish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == DP_FINISH) |-> (!r_out_valid || !i_out_stall))
        else $error("result written over a held result");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken again right after a transfer");

    a_valid_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(o_cmd.op == DP_FINISH))
        else $error("result valid without a finished item");

endmodule

@@ rtl/assc_datapath.sv @@
// ----------------------------------------------------------------------------
// assc_datapath
// Registers, config, shared 32x32 multiplier, log2/exp2 units and counters.
// ----------------------------------------------------------------------------
module assc_datapath #(
    parameter int STEP_WIDTH          = 48,
    parameter int ERROR_FRACTION_BITS = 24,
    parameter int LOG_TABLE_BITS      = 10
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  assc_pkg::t_dp_cmd      i_cmd,
    output assc_pkg::t_dp_status   o_status,
    input  logic [31:0]            i_error_estimate,
    input  logic [STEP_WIDTH-1:0]  i_step_in,
    input  logic                   i_cfg_we,
    input  logic [2:0]             i_cfg_index,
    input  logic [STEP_WIDTH-1:0]  i_cfg_data,
    output logic                   o_accepted,
    output logic [STEP_WIDTH-1:0]  o_step_out,
    output logic [1:0]             o_step_status,
    output logic [1:0]             o_scale_clamp,
    output logic [31:0]            o_accepted_total,
    output logic [31:0]            o_rejected_total,
    output logic [31:0]            o_min_clamp_total,
    output logic [31:0]            o_max_clamp_total
);
    import assc_pkg::*;

    localparam int LTB = LOG_TABLE_BITS;
    localparam logic [63:0] STEP_MASK = {64{1'b1}} >> (64 - STEP_WIDTH);
    localparam int EPS_RAW = ((1 << ERROR_FRACTION_BITS) + 5000) / 10000;
    localparam logic [31:0] EPS = 32'((EPS_RAW == 0) ? 1 : EPS_RAW);
    localparam logic [32:0] ERR_ONE = 33'(1) << ERROR_FRACTION_BITS;
    localparam logic [7:0] HEAD_FB = 8'd15;
    localparam logic [7:0] ERR_FB  = 8'(ERROR_FRACTION_BITS);
    localparam logic signed [47:0] EXP_BIAS = 48'sd1 <<< 40;
    localparam logic signed [19:0] SHIFT_FLOOR = -20'sd1042;
    localparam logic [63:0] HALF_Q30 = 64'(1) << 29;

    // configuration
    logic [15:0]           r_headroom, r_alpha, r_beta, r_min_scale, r_max_scale;
    logic [STEP_WIDTH-1:0] r_step_min, r_step_max;

    // item and history
    logic [31:0]           r_err, r_prev_err;
    logic [STEP_WIDTH-1:0] r_step;
    logic                  r_good, r_zero, r_last_rej;
    logic [31:0]           r_acc_cnt, r_rej_cnt, r_min_cnt, r_max_cnt;

    // work registers
    logic [31:0]           r_m;
    logic [15:0]           r_lfrac;
    logic signed [7:0]     r_lint;
    logic                  r_neg;
    logic [63:0]           r_prod;
    logic signed [47:0]    r_exp;
    logic [31:0]           r_acc;
    logic signed [19:0]    r_shift;
    logic [LTB-1:0]        r_efrac;
    logic [31:0]           r_scale;
    logic [1:0]            r_clamp;
    logic [STEP_WIDTH-1:0] r_nh;

    logic                  r_out_acc;
    logic [STEP_WIDTH-1:0] r_out_step;
    logic [1:0]            r_out_status, r_out_clamp;

    // combinational
    logic [31:0]           log_x;
    logic [4:0]            msb;
    logic [31+LTB:0]       norm;
    logic [LTB-1:0]        idx;
    logic [7:0]            log_fb;
    logic [15:0]           coef;
    logic signed [23:0]    log_val;
    logic [23:0]           log_mag;
    logic [31:0]           mul_a, mul_b;
    logic [63:0]           prod;
    logic [31:0]           sq;
    logic [63:0]           rnd;
    logic [LTB-1:0]        f_sh;
    logic signed [47:0]    biased;
    logic [63:0]           sh_wide;
    logic [19:0]           neg_shift;
    logic [31:0]           sc;
    logic [1:0]            clamp;
    logic [63:0]           h64;
    logic [64:0]           hsum;
    logic [63:0]           top;

    assign o_status.good     = r_good;
    assign o_status.skip_log = (r_headroom == 16'd0) || (r_good && r_zero);

    // log2 operand, zero acts as one
    always_comb begin
        unique case (i_cmd.src)
            SRC_HEADROOM: begin
                log_x  = {16'd0, r_headroom};
                log_fb = HEAD_FB;
                coef   = 16'd16384;
            end
            SRC_ERROR: begin
                log_x  = r_err;
                log_fb = ERR_FB;
                coef   = r_alpha;
            end
            default: begin
                log_x  = r_prev_err;
                log_fb = ERR_FB;
                coef   = r_beta;
            end
        endcase
        if (log_x == 32'd0) begin
            log_x = 32'd1;
        end
        msb = '0;
        for (int b = 1; b < 32; b++) begin
            if (log_x[b]) begin
                msb = 5'(b);
            end
        end
        norm = {log_x, {LTB{1'b0}}} >> msb;
        idx  = norm[LTB-1:0];
    end

    assign log_val = {r_lint, r_lfrac};
    assign log_mag = log_val[23] ? 24'(-log_val) : 24'(log_val);
    assign h64     = 64'(r_step);

    // shared multiplier
    always_comb begin
        unique case (i_cmd.op)
            DP_LOG_SQ: begin
                mul_a = r_m;
                mul_b = r_m;
            end
            DP_LOG_MUL: begin
                mul_a = {8'd0, log_mag};
                mul_b = {16'd0, coef};
            end
            DP_EXP_STEP: begin
                mul_a = r_acc;
                mul_b = ROOT_TAB[i_cmd.k];
            end
            DP_MUL_LO: begin
                mul_a = h64[31:0];
                mul_b = r_scale;
            end
            DP_MUL_HI: begin
                mul_a = h64[63:32];
                mul_b = r_scale;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod = 64'(mul_a) * 64'(mul_b);
    end

    assign sq     = prod[61:30];
    assign rnd    = prod + HALF_Q30;
    assign f_sh   = r_efrac << i_cmd.k;
    assign biased = r_exp + EXP_BIAS;

    // exponent shift and saturation
    always_comb begin
        sh_wide   = {32'd0, r_acc} << r_shift[4:0];
        neg_shift = 20'(-r_shift);
    end

    // scale bounds
    always_comb begin
        sc    = r_scale;
        clamp = CLAMP_NONE;
        if (r_good) begin
            if (r_zero) begin
                sc = {16'd0, r_max_scale};
            end else begin
                if (sc < {16'd0, r_min_scale}) begin
                    sc    = {16'd0, r_min_scale};
                    clamp = CLAMP_MIN;
                end
                if (sc > {16'd0, r_max_scale}) begin
                    sc    = {16'd0, r_max_scale};
                    clamp = CLAMP_MAX;
                end
            end
            if (r_last_rej && sc > SCALE_ONE) begin
                sc = SCALE_ONE;
            end
        end else if (sc < {16'd0, r_min_scale}) begin
            sc    = {16'd0, r_min_scale};
            clamp = CLAMP_MIN;
        end
    end

    assign top  = {prod[43:0], 20'd0};
    assign hsum = 65'(top) + 65'(r_prod[63:12]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_headroom   <= RESET_HEADROOM;
            r_alpha      <= RESET_ALPHA;
            r_beta       <= RESET_BETA;
            r_min_scale  <= RESET_MIN_SCALE;
            r_max_scale  <= RESET_MAX_SCALE;
            r_step_min   <= STEP_WIDTH'(1);
            r_step_max   <= STEP_MASK[STEP_WIDTH-1:0];
            r_prev_err   <= EPS;
            r_last_rej   <= 1'b0;
            r_acc_cnt    <= '0;
            r_rej_cnt    <= '0;
            r_min_cnt    <= '0;
            r_max_cnt    <= '0;
            r_good       <= 1'b0;
            r_zero       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_HEADROOM:  r_headroom  <= i_cfg_data[15:0];
                    CFG_ALPHA:     r_alpha     <= i_cfg_data[15:0];
                    CFG_BETA:      r_beta      <= i_cfg_data[15:0];
                    CFG_MIN_SCALE: r_min_scale <= i_cfg_data[15:0];
                    CFG_MAX_SCALE: r_max_scale <= i_cfg_data[15:0];
                    CFG_STEP_MIN:  r_step_min  <= i_cfg_data;
                    CFG_STEP_MAX:  r_step_max  <= i_cfg_data;
                    default: ;
                endcase
            end
            unique case (i_cmd.op)
                DP_LOAD: begin
                    r_good <= ({1'b0, i_error_estimate} <= ERR_ONE);
                    r_zero <= (i_error_estimate == 32'd0);
                end
                DP_FINISH: begin
                    if (r_good) begin
                        if (r_nh <= r_step_min) begin
                            r_min_cnt <= r_min_cnt + 32'd1;
                        end else if (r_nh >= r_step_max) begin
                            r_max_cnt <= r_max_cnt + 32'd1;
                        end
                        r_prev_err <= (r_err > EPS) ? r_err : EPS;
                        r_last_rej <= 1'b0;
                        r_acc_cnt  <= r_acc_cnt + 32'd1;
                    end else if (r_nh <= r_step_min) begin
                        r_min_cnt <= r_min_cnt + 32'd1;
                    end else if (r_nh >= r_step_max) begin
                        r_max_cnt <= r_max_cnt + 32'd1;
                    end else begin
                        r_last_rej <= 1'b1;
                        r_rej_cnt  <= r_rej_cnt + 32'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath payload
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            DP_LOAD: begin
                r_err   <= i_error_estimate;
                r_step  <= i_step_in;
                r_exp   <= '0;
                r_scale <= '0;
            end
            DP_LOG_INIT: begin
                r_m     <= 32'h4000_0000 | (32'(idx) << (30 - LTB));
                r_lfrac <= '0;
                r_lint  <= $signed({3'd0, msb} - log_fb);
            end
            DP_LOG_SQ: begin
                r_m     <= sq[31] ? {1'b0, sq[31:1]} : sq;
                r_lfrac <= {r_lfrac[14:0], sq[31]};
            end
            DP_LOG_MUL: begin
                r_prod <= prod;
                r_neg  <= log_val[23] ^ (i_cmd.src == SRC_ERROR);
            end
            DP_LOG_ACC: begin
                if (r_neg) begin
                    r_exp <= r_exp - $signed({8'd0, r_prod[39:0]});
                end else begin
                    r_exp <= r_exp + $signed({8'd0, r_prod[39:0]});
                end
            end
            DP_EXP_INIT: begin
                r_acc <= 32'h4000_0000;
                if (biased < 0) begin
                    r_shift <= SHIFT_FLOOR;
                    r_efrac <= '0;
                end else begin
                    r_shift <= 20'(r_exp >>> 30) - 20'sd18;
                    r_efrac <= r_exp[29 -: LTB];
                end
            end
            DP_EXP_STEP: begin
                if (f_sh[LTB-1]) begin
                    r_acc <= rnd[61:30];
                end
            end
            DP_EXP_FIN: begin
                if (!r_shift[19]) begin
                    if (r_shift > 20'sd31 || sh_wide[63:32] != 32'd0) begin
                        r_scale <= 32'hFFFF_FFFF;
                    end else begin
                        r_scale <= sh_wide[31:0];
                    end
                end else if (neg_shift >= 20'd32) begin
                    r_scale <= '0;
                end else begin
                    r_scale <= r_acc >> neg_shift[4:0];
                end
            end
            DP_CLAMP: begin
                r_scale <= sc;
                r_clamp <= clamp;
            end
            DP_MUL_LO: r_prod <= prod;
            DP_MUL_HI: begin
                if (prod[63:44] != 20'd0 || hsum[64] || hsum[63:0] > STEP_MASK) begin
                    r_nh <= STEP_MASK[STEP_WIDTH-1:0];
                end else begin
                    r_nh <= hsum[STEP_WIDTH-1:0];
                end
            end
            DP_FINISH: begin
                r_out_clamp <= r_clamp;
                if (r_nh <= r_step_min) begin
                    r_out_step   <= r_step_min;
                    r_out_status <= STATUS_MIN;
                    r_out_acc    <= 1'b1;
                end else if (r_nh >= r_step_max) begin
                    r_out_step   <= r_step_max;
                    r_out_status <= STATUS_MAX;
                    r_out_acc    <= 1'b1;
                end else begin
                    r_out_step   <= r_nh;
                    r_out_status <= STATUS_OK;
                    r_out_acc    <= r_good;
                end
            end
            default: ;
        endcase
    end

    assign o_accepted        = r_out_acc;
    assign o_step_out        = r_out_step;
    assign o_step_status     = r_out_status;
    assign o_scale_clamp     = r_out_clamp;
    assign o_accepted_total  = r_acc_cnt;
    assign o_rejected_total  = r_rej_cnt;
    assign o_min_clamp_total = r_min_cnt;
    assign o_max_clamp_total = r_max_cnt;

endmodule

@@ rtl/adaptive_step_size_controller.sv @@
// ----------------------------------------------------------------------------
// adaptive_step_size_controller
// PI step size control for an embedded Runge-Kutta integrator.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall) takes the scaled error of the step
// just tried and that step. Output channel (o_out_valid / i_out_stall) returns
// accept flag, next or retry step, clamp codes and four running counters.
// Config channel (i_cfg_valid / o_cfg_ready) writes the seven registers by
// index; write only while no item is in flight.
// One item is worked at a time. An item within tolerance takes three log2
// evaluations, one out of tolerance takes two, and none are run when the
// scale needs no logs (zero error or zero headroom).
// The next item can be taken in the cycle after the result is written.
// Each log2 takes 16 squarings on the one shared 32x32 multiplier; the exp2
// and the final step product run on the same multiplier.
// A finished result waits in the output register while the receiver stalls;
// the next item is taken meanwhile and held before its write-back.
// Reset restores register defaults, the error history and all counters.
// ----------------------------------------------------------------------------
module adaptive_step_size_controller #(
    parameter int STEP_WIDTH          = 48,
    parameter int ERROR_FRACTION_BITS = 24,
    parameter int LOG_TABLE_BITS      = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [31:0]           i_error_estimate,
    input  logic [STEP_WIDTH-1:0] i_step_in,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_accepted,
    output logic [STEP_WIDTH-1:0] o_step_out,
    output logic [1:0]            o_step_status,
    output logic [1:0]            o_scale_clamp,
    output logic [31:0]           o_accepted_total,
    output logic [31:0]           o_rejected_total,
    output logic [31:0]           o_min_clamp_total,
    output logic [31:0]           o_max_clamp_total,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [2:0]            i_cfg_index,
    input  logic [STEP_WIDTH-1:0] i_cfg_data
);
    import assc_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    assign o_cfg_ready = 1'b1;

    assc_ctrl #(
        .LOG_TABLE_BITS (LOG_TABLE_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    assc_datapath #(
        .STEP_WIDTH          (STEP_WIDTH),
        .ERROR_FRACTION_BITS (ERROR_FRACTION_BITS),
        .LOG_TABLE_BITS      (LOG_TABLE_BITS)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_error_estimate  (i_error_estimate),
        .i_step_in         (i_step_in),
        .i_cfg_we          (i_cfg_valid),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_accepted        (o_accepted),
        .o_step_out        (o_step_out),
        .o_step_status     (o_step_status),
        .o_scale_clamp     (o_scale_clamp),
        .o_accepted_total  (o_accepted_total),
        .o_rejected_total  (o_rejected_total),
        .o_min_clamp_total (o_min_clamp_total),
        .o_max_clamp_total (o_max_clamp_total)
    );

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the adaptive step size controller: an in-bench
// PI step predictor (log2/exp2 in fixed point) checks every result transfer
// under random idling on both channels and across several register settings.
// ----------------------------------------------------------------------------
module tb;
    import assc_pkg::*;

    localparam int SW = 48;
    localparam int EFB = 24;
    localparam int LTB = 10;
    localparam logic [SW-1:0] STEP_ALL = {SW{1'b1}};
    localparam logic [31:0] ERR_ONE = 32'd1 << EFB;
    localparam logic [31:0] ERR_FLOOR = 32'd1678;   // 1e-4 in Q8.24
    localparam logic [2:0] CFG_UNUSED = 3'd7;
    localparam int DRAIN_CYCLES = 100;
    localparam int STALL_LIMIT = 4000;

    typedef struct packed {
        logic          acc;
        logic [SW-1:0] step;
        logic [1:0]    status;
        logic [1:0]    clamp;
        logic [31:0]   n_acc;
        logic [31:0]   n_rej;
        logic [31:0]   n_min;
        logic [31:0]   n_max;
    } t_step_result;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_in_valid = 1'b0;
    logic          o_in_stall;
    logic [31:0]   i_error_estimate = '0;
    logic [SW-1:0] i_step_in = '0;
    logic          o_out_valid;
    logic          i_out_stall = 1'b0;
    logic          o_accepted;
    logic [SW-1:0] o_step_out;
    logic [1:0]    o_step_status;
    logic [1:0]    o_scale_clamp;
    logic [31:0]   o_accepted_total;
    logic [31:0]   o_rejected_total;
    logic [31:0]   o_min_clamp_total;
    logic [31:0]   o_max_clamp_total;
    logic          i_cfg_valid = 1'b0;
    logic          o_cfg_ready;
    logic [2:0]    i_cfg_index = '0;
    logic [SW-1:0] i_cfg_data = '0;

    adaptive_step_size_controller #(
        .STEP_WIDTH(SW), .ERROR_FRACTION_BITS(EFB), .LOG_TABLE_BITS(LTB)
    ) dut (.*);

    // predictor copy of registers and state
    logic [15:0]   headroom_q, alpha_q, beta_q, min_scale_q, max_scale_q;
    logic [SW-1:0] step_min_q, step_max_q;
    logic [31:0]   hist_err;
    logic          after_reject;
    logic [31:0]   cnt_acc, cnt_rej, cnt_min, cnt_max;

    t_step_result pending_steps[$];
    int  fail_count = 0;
    int  items_sent = 0;
    int  results_seen = 0;
    int  settings_run = 0;
    bit  no_idle = 1'b0;
    int  quiet_cycles = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint log_frac(longint unsigned i);
        longint unsigned m;
        longint r;
        m = (64'd1 << 30) | (i << (30 - LTB));
        r = 0;
        for (int k = 0; k < 16; k++) begin
            m = (m * m) >> 30;
            r = r << 1;
            if (m >= (64'd2 << 30)) begin
                m = m >> 1;
                r = r | 1;
            end
        end
        return r;
    endfunction

    // log2 with 16 fraction bits; zero counts as one lsb
    function automatic longint log2_q16(longint unsigned x, int fb);
        longint unsigned idx;
        int p;
        p = 0;
        if (x == 0) x = 1;
        while (p < 63 && (x >> (p + 1)) != 0) p++;
        if (p >= LTB) idx = (x >> (p - LTB)) & ((64'd1 << LTB) - 1);
        else idx = (x << (LTB - p)) & ((64'd1 << LTB) - 1);
        return longint'(p - fb) * 65536 + log_frac(idx);
    endfunction

    // 2^(e/2^30) in Q.12, saturated to 32 bits
    function automatic longint unsigned exp2_q12(longint e);
        longint biased, ip, s;
        longint unsigned u, f, acc;
        biased = e + (longint'(1024) << 30);
        u = biased < 0 ? 0 : biased;
        ip = longint'(u >> 30) - 1024;
        f = (u & ((64'd1 << 30) - 1)) >> (30 - LTB);
        acc = 64'd1 << 30;
        for (int k = 0; k < LTB; k++)
            if ((f >> (LTB - 1 - k)) & 1)
                acc = (acc * ROOT_TAB[k] + (64'd1 << 29)) >> 30;
        s = ip - 18;
        if (s >= 0) begin
            if (s > 31) return 64'hFFFF_FFFF;
            acc = acc << s;
        end else begin
            if (s <= -63) return 0;
            acc = acc >> (-s);
        end
        return acc > 64'hFFFF_FFFF ? 64'hFFFF_FFFF : acc;
    endfunction

    function automatic longint unsigned pi_scale(logic [31:0] err, bit use_hist);
        longint e;
        if (headroom_q == 0) return 0;
        e = log2_q16(headroom_q, 15) * 16384 - longint'(alpha_q) * log2_q16(err, EFB);
        if (use_hist) e += longint'(beta_q) * log2_q16(hist_err, EFB);
        return exp2_q12(e);
    endfunction

    function automatic logic [SW-1:0] scaled_step(logic [SW-1:0] h, longint unsigned sc);
        logic [127:0] prod;
        prod = ({80'd0, h} * {96'd0, sc[31:0]}) >> 12;
        return prod > {80'd0, STEP_ALL} ? STEP_ALL : prod[SW-1:0];
    endfunction

    function automatic void predict_step(logic [31:0] err, logic [SW-1:0] h);
        t_step_result r;
        longint unsigned sc;
        r = '0;
        r.status = STATUS_OK;
        r.clamp = CLAMP_NONE;
        if (err <= ERR_ONE) begin
            if (err == 0) begin
                sc = max_scale_q;
            end else begin
                sc = pi_scale(err, 1'b1);
                if (sc < min_scale_q) begin
                    sc = min_scale_q;
                    r.clamp = CLAMP_MIN;
                end
                if (sc > max_scale_q) begin
                    sc = max_scale_q;
                    r.clamp = CLAMP_MAX;
                end
            end
            if (after_reject && sc > SCALE_ONE) sc = SCALE_ONE;
            r.step = scaled_step(h, sc);
            if (r.step <= step_min_q) begin
                r.step = step_min_q;
                r.status = STATUS_MIN;
                cnt_min++;
            end else if (r.step >= step_max_q) begin
                r.step = step_max_q;
                r.status = STATUS_MAX;
                cnt_max++;
            end
            hist_err = err > ERR_FLOOR ? err : ERR_FLOOR;
            after_reject = 1'b0;
            cnt_acc++;
            r.acc = 1'b1;
        end else begin
            sc = pi_scale(err, 1'b0);
            if (sc < min_scale_q) begin
                sc = min_scale_q;
                r.clamp = CLAMP_MIN;
            end
            r.step = scaled_step(h, sc);
            r.acc = 1'b1;
            if (r.step <= step_min_q) begin
                r.step = step_min_q;
                r.status = STATUS_MIN;
                cnt_min++;
            end else if (r.step >= step_max_q) begin
                r.step = step_max_q;
                r.status = STATUS_MAX;
                cnt_max++;
            end else begin
                after_reject = 1'b1;
                cnt_rej++;
                r.acc = 1'b0;
            end
        end
        r.n_acc = cnt_acc;
        r.n_rej = cnt_rej;
        r.n_min = cnt_min;
        r.n_max = cnt_max;
        pending_steps.push_back(r);
    endfunction

    // all drive tasks are entered and left at a falling edge
    task automatic send_item(logic [31:0] err, logic [SW-1:0] h);
        int gap;
        if (!no_idle && $urandom_range(99) < 34) begin
            gap = $urandom_range(1, 6);
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_error_estimate = err;
        i_step_in = h;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_step(err, h);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain;
        i_in_valid = 1'b0;
        while (pending_steps.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [SW-1:0] val);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_HEADROOM:  headroom_q = val[15:0];
            CFG_ALPHA:     alpha_q = val[15:0];
            CFG_BETA:      beta_q = val[15:0];
            CFG_MIN_SCALE: min_scale_q = val[15:0];
            CFG_MAX_SCALE: max_scale_q = val[15:0];
            CFG_STEP_MIN:  step_min_q = val;
            CFG_STEP_MAX:  step_max_q = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic load_settings(logic [15:0] hr, logic [15:0] al, logic [15:0] be,
                                 logic [15:0] smin, logic [15:0] smax,
                                 logic [SW-1:0] hmin, logic [SW-1:0] hmax);
        drain();
        write_reg(CFG_HEADROOM, SW'(hr));
        write_reg(CFG_ALPHA, SW'(al));
        write_reg(CFG_BETA, SW'(be));
        write_reg(CFG_MIN_SCALE, SW'(smin));
        write_reg(CFG_MAX_SCALE, SW'(smax));
        write_reg(CFG_STEP_MIN, hmin);
        write_reg(CFG_STEP_MAX, hmax);
        settings_run++;
    endtask

    function automatic logic [31:0] rand_err();
        int pick;
        pick = $urandom_range(99);
        if (pick < 45) return $urandom_range(0, ERR_ONE);
        if (pick < 65) return ERR_ONE + $urandom_range(0, 64) - 32;
        if (pick < 85) return $urandom >> $urandom_range(0, 7);
        return $urandom >> $urandom_range(8, 31);
    endfunction

    function automatic logic [SW-1:0] rand_step();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v[SW-1:0] >> $urandom_range(0, SW - 1);
    endfunction

    task automatic test_defaults;
        send_item(32'd0, 48'd1000);
        send_item(ERR_ONE, 48'd1000);
        send_item(ERR_ONE + 1, 48'd1000);
        send_item(32'hFFFF_FFFF, 48'd1000000);
        send_item(32'd0, 48'd1000);          // capped at one after a rejection
        send_item(32'd1, STEP_ALL);
        send_item(32'd5000, 48'd0);
        send_item(32'hFFFF_FFFF, 48'd1);     // accepted at step_min
        send_item(32'd0, STEP_ALL);          // accepted at step_max
    endtask

    task automatic test_register_corners;
        // zero headroom forces the min_scale raise
        load_settings(16'd0, RESET_ALPHA, RESET_BETA, RESET_MIN_SCALE, RESET_MAX_SCALE,
                      48'd1, STEP_ALL);
        send_item(32'd100000, 48'd123456);
        send_item(ERR_ONE * 2, 48'd123456);
        // inverted scale bounds
        load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 48'd0, STEP_ALL);
        send_item(32'd1, 48'd99999);
        send_item(32'd9, 48'd99999);
        send_item(32'hFFFF_FFFF, 48'd99999);
        // inverted step bounds: step_min wins when both bounds are met
        load_settings(RESET_HEADROOM, 16'd0, 16'd0, 16'd0, 16'hFFFF, 48'd5000, 48'd10);
        send_item(ERR_ONE >> 1, 48'd3000);
        send_item(ERR_ONE * 4, 48'd3000000);
        // large error accepted at step_max, then a small step rejected below it
        load_settings(RESET_HEADROOM, RESET_ALPHA, RESET_BETA, 16'd8192, 16'hFFFF,
                      48'd0, 48'd100);
        send_item(ERR_ONE * 8, 48'd500);
        send_item(32'h8000_0000, 48'd20);
        drain();
        write_reg(CFG_UNUSED, STEP_ALL);
    endtask

    task automatic random_phase(int count);
        for (int n = 0; n < count; n++) send_item(rand_err(), rand_step());
    endtask

    task automatic test_random;
        load_settings(RESET_HEADROOM, RESET_ALPHA, RESET_BETA, RESET_MIN_SCALE,
                      RESET_MAX_SCALE, 48'd1, STEP_ALL);
        random_phase(200);
        no_idle = 1'b1;
        random_phase(100);
        no_idle = 1'b0;
        for (int ph = 0; ph < 4; ph++) begin
            load_settings(16'($urandom), 16'($urandom_range(0, 8192)),
                          16'($urandom_range(0, 8192)), 16'($urandom_range(0, 4096)),
                          16'($urandom_range(4096, 65535)), SW'($urandom_range(0, 1000)),
                          STEP_ALL >> $urandom_range(0, 20));
            random_phase(60);
        end
        load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF, 48'd0, STEP_ALL);
        random_phase(80);
        load_settings(16'd1, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF, STEP_ALL, STEP_ALL);
        random_phase(40);
        drain();
    endtask

    always @(negedge i_clk)
        i_out_stall <= !no_idle && ($urandom_range(99) < 34);

    always @(posedge i_clk) begin
        t_step_result want;
        if (o_out_valid && !i_out_stall) begin
            results_seen++;
            if (pending_steps.size() == 0) begin
                $error("result transfer with no expectation pending");
                fail_count++;
            end else begin
                want = pending_steps.pop_front();
                if (o_accepted !== want.acc) begin
                    $error("accepted: exp %0d got %0d", want.acc, o_accepted);
                    fail_count++;
                end
                if (o_step_out !== want.step) begin
                    $error("step_out: exp %0d got %0d", want.step, o_step_out);
                    fail_count++;
                end
                if (o_step_status !== want.status) begin
                    $error("step_status: exp %0d got %0d", want.status, o_step_status);
                    fail_count++;
                end
                if (o_scale_clamp !== want.clamp) begin
                    $error("scale_clamp: exp %0d got %0d", want.clamp, o_scale_clamp);
                    fail_count++;
                end
                if (o_accepted_total !== want.n_acc) begin
                    $error("accepted_total: exp %0d got %0d", want.n_acc, o_accepted_total);
                    fail_count++;
                end
                if (o_rejected_total !== want.n_rej) begin
                    $error("rejected_total: exp %0d got %0d", want.n_rej, o_rejected_total);
                    fail_count++;
                end
                if (o_min_clamp_total !== want.n_min) begin
                    $error("min_clamp_total: exp %0d got %0d", want.n_min, o_min_clamp_total);
                    fail_count++;
                end
                if (o_max_clamp_total !== want.n_max) begin
                    $error("max_clamp_total: exp %0d got %0d", want.n_max, o_max_clamp_total);
                    fail_count++;
                end
            end
        end
    end

    // count cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        headroom_q = RESET_HEADROOM;
        alpha_q = RESET_ALPHA;
        beta_q = RESET_BETA;
        min_scale_q = RESET_MIN_SCALE;
        max_scale_q = RESET_MAX_SCALE;
        step_min_q = 48'd1;
        step_max_q = STEP_ALL;
        hist_err = ERR_FLOOR;
        after_reject = 1'b0;
        cnt_acc = 0;
        cnt_rej = 0;
        cnt_min = 0;
        cnt_max = 0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        test_defaults();
        test_register_corners();
        test_random();
        $display("covered %0d items, %0d results, %0d register settings",
                 items_sent, results_seen, settings_run);
        if (fail_count == 0 && pending_steps.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
